// ===== sv/sv39ptw_pkg.sv =====
package sv39ptw_pkg;

   // Pool geometry
   localparam int POOL_PAGES       = 64;
   localparam int ENTRIES_PER_PAGE = 512;
   localparam int PAGE_W           = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
   localparam int SLOT_W           = $clog2(ENTRIES_PER_PAGE);
   localparam int ADDR_W           = PAGE_W + SLOT_W;
   localparam int STORE_DEPTH      = POOL_PAGES * ENTRIES_PER_PAGE;
   localparam int NFP_W            = $clog2(POOL_PAGES + 1);

   // Field widths
   localparam int VA_W        = 39;
   localparam int PA_W        = 56;
   localparam int PPN_W       = 44;
   localparam int PERM_W      = 10;
   localparam int ENTRY_W     = 64;
   localparam int STATUS_W    = 3;
   localparam int LEAF_PAGE_W = 6;
   localparam int VPN_W       = 9;

   localparam logic [PA_W-1:0] POOL_BASE_RESET = 56'h0000_0000_8000_0000;

   // Commands
   localparam logic CMD_MAP  = 1'b0;
   localparam logic CMD_WALK = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_MISALIGNED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MAPPED     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_MISSING    = 3'd4;

   typedef enum logic [1:0] {
      LVL_LEAF = 2'd0,
      LVL_MID  = 2'd1,
      LVL_ROOT = 2'd2
   } level_type;

   typedef struct packed {
      logic              cmd;
      logic [VA_W-1:0]   va;
      logic [PA_W-1:0]   pa;
      logic [PERM_W-1:0] perm;
      logic              alloc;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [ENTRY_W-1:0]     leaf_entry;
      logic [LEAF_PAGE_W-1:0] leaf_page;
      logic [SLOT_W-1:0]      leaf_slot;
   } rsp_type;

   // VPN field of a virtual address at a given level
   function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                                input level_type lvl);
      logic [VPN_W-1:0] v;
      case (lvl)
         LVL_ROOT: v = va[38:30];
         LVL_MID:  v = va[29:21];
         default:  v = va[20:12];
      endcase
      return v;
   endfunction

   // Valid pointer entry to pool page pg
   function automatic logic [ENTRY_W-1:0] ptr_pte(input logic [PA_W-1:0] base,
                                                  input logic [PAGE_W-1:0] pg);
      logic [PPN_W-1:0] ppn;
      ppn = base[PA_W-1:12] + PPN_W'(pg);
      return {10'b0, ppn, 10'b0} | ENTRY_W'(1);
   endfunction

   // Leaf entry for a map
   function automatic logic [ENTRY_W-1:0] leaf_pte(input logic [PA_W-1:0] pa,
                                                   input logic [PERM_W-1:0] perm);
      return {10'b0, pa[PA_W-1:12], perm} | ENTRY_W'(1);
   endfunction

endpackage

// ===== sv/sv39_page_table_walk_map.sv =====
// Channel   Dir  Handshake          Payload
// req       in   req_valid/stall    sv39ptw_pkg::req_type (cmd, va, pa, perm, alloc)
// rsp       out  rsp_valid/stall    sv39ptw_pkg::rsp_type (status, leaf_entry, page, slot)
// csr       in   csr_valid/ready    pool_base, 56 bits
//
// A request walks the root, mid and leaf levels with dependent reads of the table store,
// whose one read port is registered, until a leaf or a fault, then loads the result register.
// Each table page allocated on the way adds a reread of that page; a misaligned map reads nothing.
// After reset a clearing pass zeroes the store, one entry a cycle, all 32768 entries
// (POOL_PAGES * ENTRIES_PER_PAGE); requests are stalled meanwhile, csr writes are not.
// One request at a time; a new one is taken while the previous result still waits.
module sv39_page_table_walk_map (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sv39ptw_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sv39ptw_pkg::rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [55:0]          csr_data
);
   import sv39ptw_pkg::*;

   typedef enum logic [4:0] {
      S_CLEAR  = 5'b00001,
      S_IDLE   = 5'b00010,
      S_EVAL   = 5'b00100,
      S_REREAD = 5'b01000,
      S_FIN    = 5'b10000
   } state_type;

   // Table store: one write and one registered read per cycle
   logic [ENTRY_W-1:0] store_mem [STORE_DEPTH];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_ff, clr_in;
   logic [NFP_W-1:0]   nfp_ff, nfp_in;
   logic [PA_W-1:0]    base_ff, base_in;
   req_type            req_ff, req_in;
   level_type          lvl_ff, lvl_in;
   logic [PAGE_W-1:0]  cur_ff, cur_in;
   rsp_type            pend_ff, pend_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   // Store port controls
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   // Decode of the entry just read
   logic [PPN_W-1:0]   ptr_pg;
   logic               ptr_in_pool;
   logic               pool_full;
   logic               may_alloc;
   logic               out_free;
   rsp_type            res;
   logic               finish;
   level_type          lvl_next;

   assign ptr_pg      = rd_data_ff[53:10] - base_ff[PA_W-1:12];
   assign ptr_in_pool = ptr_pg < PPN_W'(POOL_PAGES);
   assign pool_full   = nfp_ff >= NFP_W'(POOL_PAGES);
   assign may_alloc   = (req_ff.cmd == CMD_MAP) || req_ff.alloc;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign lvl_next    = (lvl_ff == LVL_ROOT) ? LVL_MID : LVL_LEAF;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      nfp_in       = nfp_ff;
      base_in      = base_ff;
      req_in       = req_ff;
      lvl_in       = lvl_ff;
      cur_in       = cur_ff;
      pend_in      = pend_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rd_en        = 1'b0;
      rd_addr      = {cur_ff, vpn_of(req_ff.va, lvl_ff)};
      wr_en        = 1'b0;
      wr_addr      = clr_ff;
      wr_data      = '0;
      res          = '0;
      finish       = 1'b0;

      if (csr_valid) begin
         base_in = csr_data;
      end

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            clr_in = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(STORE_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               cur_in = '0;
               lvl_in = LVL_ROOT;
               if (req_data.cmd == CMD_MAP &&
                   (req_data.va[11:0] != '0 || req_data.pa[11:0] != '0)) begin
                  pend_in        = '0;
                  pend_in.status = ST_MISALIGNED;
                  state_in       = S_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = {{PAGE_W{1'b0}}, vpn_of(req_data.va, LVL_ROOT)};
                  state_in = S_EVAL;
               end
            end
         end
         S_REREAD: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (lvl_ff == LVL_LEAF) begin
               // leaf entry in rd_data_ff
               res.status     = ST_OK;
               res.leaf_entry = rd_data_ff;
               res.leaf_page  = LEAF_PAGE_W'(cur_ff);
               res.leaf_slot  = vpn_of(req_ff.va, LVL_LEAF);
               if (req_ff.cmd == CMD_MAP) begin
                  if (rd_data_ff[0]) begin
                     res.status = ST_MAPPED;
                  end else begin
                     wr_en          = 1'b1;
                     wr_addr        = {cur_ff, vpn_of(req_ff.va, LVL_LEAF)};
                     wr_data        = leaf_pte(req_ff.pa, req_ff.perm);
                     res.leaf_entry = wr_data;
                  end
               end
               finish = 1'b1;
            end else if (rd_data_ff[0]) begin
               // follow a valid pointer
               if (!ptr_in_pool) begin
                  res.status = ST_MISSING;
                  finish     = 1'b1;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = {ptr_pg[PAGE_W-1:0], vpn_of(req_ff.va, lvl_next)};
                  cur_in  = ptr_pg[PAGE_W-1:0];
                  lvl_in  = lvl_next;
               end
            end else if (!may_alloc) begin
               res.status = ST_MISSING;
               finish     = 1'b1;
            end else if (pool_full) begin
               res.status = ST_EXHAUSTED;
               finish     = 1'b1;
            end else begin
               // link a fresh page; read it next cycle so the write lands first
               wr_en    = 1'b1;
               wr_addr  = {cur_ff, vpn_of(req_ff.va, lvl_ff)};
               wr_data  = ptr_pte(base_ff, nfp_ff[PAGE_W-1:0]);
               cur_in   = nfp_ff[PAGE_W-1:0];
               nfp_in   = nfp_ff + NFP_W'(1);
               lvl_in   = lvl_next;
               state_in = S_REREAD;
            end
            if (finish) begin
               if (out_free) begin
                  rsp_in       = res;
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  pend_in  = res;
                  state_in = S_FIN;
               end
            end
         end
         S_FIN: begin
            if (out_free) begin
               rsp_in       = pend_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         nfp_ff       <= NFP_W'(1);
         base_ff      <= POOL_BASE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nfp_ff       <= nfp_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      lvl_ff  <= lvl_in;
      cur_ff  <= cur_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   // Store memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

endmodule
